FILE: rtl/nsd_pkg.sv
package nsd_pkg;

    localparam int OUT_BITS  = 16;
    localparam int STEP_BITS = 3;

    typedef logic [STEP_BITS-1:0] step_t;

    typedef enum logic [2:0] {
        COND_NEVER       = 3'd0,
        COND_ALWAYS      = 3'd1,
        COND_NOT_ACCEPT  = 3'd2,
        COND_NOT_GREATER = 3'd3,
        COND_NOT_FIN     = 3'd4,
        COND_FILL_NZ     = 3'd5
    } cond_t;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_LATCH  = 3'd1,
        ACT_POP    = 3'd2,
        ACT_PUSH   = 3'd3,
        ACT_FLUSH  = 3'd4,
        ACT_FINISH = 3'd5
    } act_t;

    typedef struct packed {
        logic  ready;
        act_t  act;
        cond_t cond;
        step_t target;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic greater;
        logic fill_nz;
        logic fin;
        logic stall;
    } seq_status_t;

    localparam step_t S_IDLE   = 3'd0;
    localparam step_t S_WAIT   = 3'd1;
    localparam step_t S_CMP    = 3'd2;
    localparam step_t S_POP    = 3'd3;
    localparam step_t S_PUSH   = 3'd4;
    localparam step_t S_FWAIT  = 3'd5;
    localparam step_t S_FLUSH  = 3'd6;
    localparam step_t S_FINISH = 3'd7;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '{ready: 1'b0, act: ACT_NONE, cond: COND_NEVER, target: S_IDLE};
        unique case (step)
            S_IDLE:   w = '{ready: 1'b1, act: ACT_LATCH,  cond: COND_NOT_ACCEPT,
                            target: S_IDLE};
            S_WAIT:   w = '{ready: 1'b0, act: ACT_NONE,   cond: COND_NEVER,
                            target: S_IDLE};
            S_CMP:    w = '{ready: 1'b0, act: ACT_NONE,   cond: COND_NOT_GREATER,
                            target: S_PUSH};
            S_POP:    w = '{ready: 1'b0, act: ACT_POP,    cond: COND_ALWAYS,
                            target: S_WAIT};
            S_PUSH:   w = '{ready: 1'b0, act: ACT_PUSH,   cond: COND_NOT_FIN,
                            target: S_FINISH};
            S_FWAIT:  w = '{ready: 1'b0, act: ACT_NONE,   cond: COND_NEVER,
                            target: S_IDLE};
            S_FLUSH:  w = '{ready: 1'b0, act: ACT_FLUSH,  cond: COND_FILL_NZ,
                            target: S_FWAIT};
            S_FINISH: w = '{ready: 1'b0, act: ACT_FINISH, cond: COND_ALWAYS,
                            target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/nsd_stack_ram.sv
module nsd_stack_ram #(
    parameter int DEPTH = 63,
    parameter int WIDTH = 32,
    parameter int ADDR_BITS = 6
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/nsd_sequencer.sv
module nsd_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  nsd_pkg::seq_status_t status,
    output nsd_pkg::ucode_t     ctrl
);
    import nsd_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    ucode_t word;
    logic   take;

    assign word = ucode_rom(step_reg);
    assign ctrl = word;

    always_comb
    begin
        case (word.cond)
            COND_ALWAYS:      take = 1'b1;
            COND_NOT_ACCEPT:  take = !status.in_valid;
            COND_NOT_GREATER: take = !status.greater;
            COND_NOT_FIN:     take = !status.fin;
            COND_FILL_NZ:     take = status.fill_nz;
            default:          take = 1'b0;
        endcase
    end

    always_comb
    begin
        if (status.stall)
        begin
            step_next = step_reg;
        end
        else if (take)
        begin
            step_next = word.target;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

FILE: rtl/next_smaller_distance_stack.sv
// Each result waits in a holding register until the next result or the end of its item,
// then leaves through one output register. A new item is accepted only in the idle step,
// once the previous item is finished. The time per item is set by the step sequencer and
// the registered stack read port, grows with each popped entry and, for a final item, with
// each flushed entry, and includes any time held while the output register is full.
// Reset: stack empty, position counter at 0, no result pending; stack memory is not
// cleared and needs no clearing pass.
module next_smaller_distance_stack #(
    parameter int STACK_DEPTH   = 63,
    parameter int VALUE_BITS    = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] price,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] position,
    output logic [15:0] span,
    output logic        overflow,
    output logic        end_of_run
);
    import nsd_pkg::*;

    localparam int FILL_BITS = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_BITS = $clog2(STACK_DEPTH);
    localparam int ENTRY_BITS = VALUE_BITS + POSITION_BITS;

    ucode_t      ctrl;
    seq_status_t status;

    logic [VALUE_BITS-1:0]    val_reg;
    logic                     fin_reg;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] next_pos_reg;
    logic [FILL_BITS-1:0]     fill_reg;
    logic [FILL_BITS-1:0]     fill_next;

    logic                     hold_valid_reg;
    logic [POSITION_BITS-1:0] hold_pos_reg;
    logic [POSITION_BITS-1:0] hold_span_reg;
    logic                     hold_ovf_reg;

    logic                     out_valid_reg;
    logic [OUT_BITS-1:0]      out_pos_reg;
    logic [OUT_BITS-1:0]      out_span_reg;
    logic                     out_ovf_reg;
    logic                     out_eor_reg;

    logic [ENTRY_BITS-1:0]    rd_entry;
    logic [VALUE_BITS-1:0]    top_val;
    logic [POSITION_BITS-1:0] top_pos;
    logic [ADDR_BITS-1:0]     rd_addr;
    logic                     we;

    logic accept;
    logic fill_nz;
    logic full;
    logic greater;
    logic emit_req;
    logic slot_free;
    logic stall;
    logic move_hold;
    logic dec;
    logic [POSITION_BITS-1:0] new_pos;
    logic [POSITION_BITS-1:0] new_span;
    logic                     new_ovf;

    nsd_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    nsd_stack_ram #(
        .DEPTH     (STACK_DEPTH),
        .WIDTH     (ENTRY_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (ADDR_BITS'(fill_reg)),
        .wdata ({val_reg, pos_reg}),
        .raddr (rd_addr),
        .rdata (rd_entry)
    );

    assign top_val = rd_entry[ENTRY_BITS-1:POSITION_BITS];
    assign top_pos = rd_entry[POSITION_BITS-1:0];

    assign fill_nz = (fill_reg != '0);
    assign full    = (fill_reg == FILL_BITS'(STACK_DEPTH));
    assign rd_addr = fill_nz ? ADDR_BITS'(fill_reg - 1'b1) : '0;
    assign greater = fill_nz && (top_val > val_reg);

    assign in_ready = ctrl.ready;
    assign accept   = in_valid && in_ready;

    assign emit_req = (ctrl.act == ACT_POP)
                   || ((ctrl.act == ACT_PUSH) && full)
                   || ((ctrl.act == ACT_FLUSH) && fill_nz);

    assign slot_free = !out_valid_reg || out_ready;
    assign stall     = hold_valid_reg && !slot_free
                    && (emit_req || (ctrl.act == ACT_FINISH));
    assign move_hold = !stall && hold_valid_reg
                    && (emit_req || (ctrl.act == ACT_FINISH));

    assign dec = !stall && (((ctrl.act == ACT_POP))
                         || ((ctrl.act == ACT_FLUSH) && fill_nz));
    assign we  = (ctrl.act == ACT_PUSH) && !full;

    assign status = '{in_valid: in_valid, greater: greater, fill_nz: fill_nz,
                      fin: fin_reg, stall: stall};

    always_comb
    begin
        if (ctrl.act == ACT_PUSH)
        begin
            new_pos  = pos_reg;
            new_span = '0;
            new_ovf  = 1'b1;
        end
        else
        begin
            new_pos  = top_pos;
            new_span = pos_reg - top_pos;
            new_ovf  = 1'b0;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (dec)
        begin
            fill_next = fill_reg - 1'b1;
        end
        else if (we)
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            next_pos_reg   <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (accept)
            begin
                next_pos_reg <= last ? '0 : next_pos_reg + 1'b1;
            end
            if (!stall && emit_req)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (!stall && (ctrl.act == ACT_FINISH))
            begin
                hold_valid_reg <= 1'b0;
            end
            if (move_hold)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            val_reg <= VALUE_BITS'(price);
            fin_reg <= last;
            pos_reg <= next_pos_reg;
        end
        if (!stall && emit_req)
        begin
            hold_pos_reg  <= new_pos;
            hold_span_reg <= new_span;
            hold_ovf_reg  <= new_ovf;
        end
        if (move_hold)
        begin
            out_pos_reg  <= OUT_BITS'(hold_pos_reg);
            out_span_reg <= OUT_BITS'(hold_span_reg);
            out_ovf_reg  <= hold_ovf_reg;
            out_eor_reg  <= (ctrl.act == ACT_FINISH);
        end
    end

    assign out_valid  = out_valid_reg;
    assign position   = out_pos_reg;
    assign span       = out_span_reg;
    assign overflow   = out_ovf_reg;
    assign end_of_run = out_eor_reg;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int STACK_DEPTH    = 63;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic [15:0] position;
        logic [15:0] span;
        logic        overflow;
        logic        end_of_run;
    } report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] price = 16'd0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] position;
    logic [15:0] span;
    logic        overflow;
    logic        end_of_run;

    logic [15:0] shadow_value [0:STACK_DEPTH-1];
    logic [15:0] shadow_position [0:STACK_DEPTH-1];
    int          shadow_fill = 0;
    logic [15:0] shadow_next = 16'd0;

    report_t     expected_reports [$];
    report_t     oldest_report;
    int          errors = 0;
    bit          idling = 1'b1;
    int unsigned sink_hold = 0;
    int          quiet_cycles = 0;

    next_smaller_distance_stack uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .price      (price),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .position   (position),
        .span       (span),
        .overflow   (overflow),
        .end_of_run (end_of_run)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void predict_reports(input logic [15:0] value, input logic fin);
        report_t     batch [0:STACK_DEPTH];
        logic [15:0] here;
        int          count;
        here = shadow_next;
        count = 0;
        while (shadow_fill > 0 && shadow_value[shadow_fill-1] > value)
        begin
            batch[count] = '0;
            batch[count].position = shadow_position[shadow_fill-1];
            batch[count].span = here - shadow_position[shadow_fill-1];
            count++;
            shadow_fill--;
        end
        if (shadow_fill < STACK_DEPTH)
        begin
            shadow_value[shadow_fill] = value;
            shadow_position[shadow_fill] = here;
            shadow_fill++;
        end
        else
        begin
            batch[count] = '0;
            batch[count].position = here;
            batch[count].overflow = 1'b1;
            count++;
        end
        if (fin)
        begin
            while (shadow_fill > 0)
            begin
                batch[count] = '0;
                batch[count].position = shadow_position[shadow_fill-1];
                batch[count].span = here - shadow_position[shadow_fill-1];
                count++;
                shadow_fill--;
            end
            shadow_next = 16'd0;
        end
        else
        begin
            shadow_next = here + 16'd1;
        end
        if (count > 0)
            batch[count-1].end_of_run = 1'b1;
        for (int k = 0; k < count; k++)
            expected_reports.push_back(batch[k]);
    endfunction

    function automatic void report_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            predict_reports(price, last);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_reports.size() == 0)
            begin
                errors++;
                $display({"%0t: unexpected result, expected none, actual position=%0d",
                          " span=%0d overflow=%b end_of_run=%b"},
                         $time, position, span, overflow, end_of_run);
            end
            else
            begin
                oldest_report = expected_reports.pop_front();
                report_field("position", oldest_report.position, position);
                report_field("span", oldest_report.span, span);
                report_field("overflow", {15'd0, oldest_report.overflow}, {15'd0, overflow});
                report_field("end_of_run", {15'd0, oldest_report.end_of_run},
                             {15'd0, end_of_run});
            end
        end
    end

    always @(negedge clk)
    begin
        if (sink_hold != 0)
            sink_hold--;
        else if (idling && $urandom_range(0, 7) == 0)
            sink_hold = $urandom_range(1, 15);
        out_ready <= (sink_hold == 0);
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("next_smaller_distance_stack regression: fail");
        $finish;
    end

    task automatic send_price(input logic [15:0] value, input logic fin);
        if (idling && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid <= 1'b1;
        price <= value;
        last <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_directed_sequences();
        send_price(16'hFFFF, 1'b1);
        send_price(16'd5, 1'b0);
        send_price(16'd3, 1'b0);
        send_price(16'd3, 1'b0);
        send_price(16'd8, 1'b0);
        send_price(16'hFFFF, 1'b0);
        send_price(16'd0, 1'b0);
        send_price(16'd0, 1'b1);
        send_price(16'hAAAA, 1'b0);
        send_price(16'h5555, 1'b0);
        send_price(16'h8000, 1'b1);
        send_price(16'd7, 1'b0);
        send_price(16'd2, 1'b1);
    endtask

    task automatic test_full_stack();
        for (int k = 0; k < STACK_DEPTH; k++)
            send_price(16'(k * 1000), 1'b0);
        send_price(16'hFFFF, 1'b0);
        send_price(16'hFFFF, 1'b1);
    endtask

    task automatic test_random_sequences();
        int          sent;
        int          seq_len;
        int          mode;
        logic [15:0] value;
        sent = 0;
        while (sent < 20)
        begin
            mode = $urandom_range(0, 3);
            seq_len = $urandom_range(1, 12);
            for (int k = 0; k < seq_len; k++)
            begin
                case (mode)
                    0: value = 16'($urandom);
                    1: value = 16'($urandom_range(0, 7));
                    2: value = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                    default:
                        if ($urandom_range(0, 9) == 0)
                            value = 16'($urandom);
                        else
                            value = 16'(k * 900 + $urandom_range(0, 899));
                endcase
                send_price(value, k == seq_len - 1);
            end
            sent += seq_len;
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_sequences();
        test_random_sequences();
        idling = 1'b0;
        test_full_stack();

        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("next_smaller_distance_stack regression: pass");
        else
            $display("next_smaller_distance_stack regression: fail");
        $finish;
    end

endmodule
